// ===== design/accident_doubt_point_capture_defines.svh =====
// Assertion macros for the point capture block.
// Used by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef ACCIDENT_DOUBT_POINT_CAPTURE_DEFINES_SVH
`define ACCIDENT_DOUBT_POINT_CAPTURE_DEFINES_SVH

// same-cycle implication
`define ADPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ADPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/adpc_pkg.sv =====
// Shared constants, register codes and microcode table for the point capture block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package adpc_pkg;

    localparam int SPEED_W    = 8;
    localparam int STATUS_W   = 8;
    localparam int VOLT_W     = 10;
    localparam int POINT_W    = SPEED_W + STATUS_W;
    localparam int DEBOUNCE_W = 16;
    localparam int SAMPLE_W   = 8;
    localparam int OFFSET_W   = 8;
    localparam int VRP_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int RING_DEPTH_DEF  = 150;
    localparam int READ_POINTS_DEF = 100;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST  = 16'd200;
    localparam logic [SAMPLE_W-1:0]   SAMPLE_RST    = 8'd4;
    localparam logic [OFFSET_W-1:0]   OFFSET_RST    = 8'd50;
    localparam logic [VRP_W-1:0]      VRP_RST       = 7'd50;
    localparam logic [VOLT_W-1:0]     THRESHOLD_RST = 10'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE  = 3'd0,
        CFG_SAMPLE    = 3'd1,
        CFG_OFFSET    = 3'd2,
        CFG_VRP       = 3'd3,
        CFG_THRESHOLD = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        UOP_NONE     = 3'd0,
        UOP_LATCH    = 3'd1,
        UOP_DEBOUNCE = 3'd2,
        UOP_STORE    = 3'd3,
        UOP_TRIGGER  = 3'd4,
        UOP_READ     = 3'd5,
        UOP_EMIT     = 3'd6
    } uop_t;

    typedef enum logic [2:0] {
        C_NEVER      = 3'd0,
        C_ALWAYS     = 3'd1,
        C_NOT_ACCEPT = 3'd2,
        C_NO_TRIG    = 3'd3,
        C_OUT_BUSY   = 3'd4,
        C_MORE_PAIRS = 3'd5
    } cond_t;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT     = 3'd0;
    localparam step_t STEP_DEBOUNCE = 3'd1;
    localparam step_t STEP_STORE    = 3'd2;
    localparam step_t STEP_TRIGGER  = 3'd3;
    localparam step_t STEP_READ     = 3'd4;
    localparam step_t STEP_EMIT     = 3'd5;
    localparam step_t STEP_LOOP     = 3'd6;
    localparam step_t STEP_DONE     = 3'd7;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // jump to target when cond holds, else fall through to the next step
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        unique case (s)
            STEP_WAIT:     w = '{UOP_LATCH,    C_NOT_ACCEPT, STEP_WAIT};
            STEP_DEBOUNCE: w = '{UOP_DEBOUNCE, C_NEVER,      STEP_WAIT};
            STEP_STORE:    w = '{UOP_STORE,    C_NEVER,      STEP_WAIT};
            STEP_TRIGGER:  w = '{UOP_TRIGGER,  C_NO_TRIG,    STEP_WAIT};
            STEP_READ:     w = '{UOP_READ,     C_NEVER,      STEP_WAIT};
            STEP_EMIT:     w = '{UOP_EMIT,     C_OUT_BUSY,   STEP_EMIT};
            STEP_LOOP:     w = '{UOP_NONE,     C_MORE_PAIRS, STEP_EMIT};
            STEP_DONE:     w = '{UOP_NONE,     C_ALWAYS,     STEP_WAIT};
            default:       w = '{UOP_NONE,     C_ALWAYS,     STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/adpc_if.sv =====
// Valid/ready channel interfaces for tick items and record pair items.
// Depends on adpc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface adpc_in_if;
    import adpc_pkg::*;

    logic                valid;
    logic                ready;
    logic [SPEED_W-1:0]  speed;
    logic [STATUS_W-1:0] status_bits;
    logic [VOLT_W-1:0]   supply_voltage;

    modport source (output valid, output speed, output status_bits, output supply_voltage,
                    input ready);
    modport sink (input valid, input speed, input status_bits, input supply_voltage,
                  output ready);
endinterface

interface adpc_out_if;
    import adpc_pkg::*;

    logic                valid;
    logic                ready;
    logic [SPEED_W-1:0]  speed_newer;
    logic [STATUS_W-1:0] status_newer;
    logic [SPEED_W-1:0]  speed_older;
    logic [STATUS_W-1:0] status_older;
    logic                cause;
    logic                record_last;
    logic                record_valid;
    logic                vehicle_running;

    modport source (output valid, output speed_newer, output status_newer,
                    output speed_older, output status_older, output cause,
                    output record_last, output record_valid, output vehicle_running,
                    input ready);
    modport sink (input valid, input speed_newer, input status_newer,
                  input speed_older, input status_older, input cause,
                  input record_last, input record_valid, input vehicle_running,
                  output ready);
endinterface

`default_nettype wire

// ===== design/adpc_ring.sv =====
// Point ring memory: one write port, two registered read ports, per-entry valid bits.
// Depends on adpc_pkg for the point width.
`timescale 1ns / 1ps
`default_nettype none

module adpc_ring #(
    parameter int DEPTH = adpc_pkg::RING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [adpc_pkg::POINT_W-1:0] wdata,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr_a,
    input  wire logic [AW-1:0]               raddr_b,
    output logic      [adpc_pkg::POINT_W-1:0] rdata_a,
    output logic      [adpc_pkg::POINT_W-1:0] rdata_b
);
    import adpc_pkg::*;

    logic [POINT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   filled_reg;
    logic [POINT_W-1:0] rd_a_reg;
    logic [POINT_W-1:0] rd_b_reg;
    logic               rdv_a_reg;
    logic               rdv_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            rdv_a_reg  <= 1'b0;
            rdv_b_reg  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                filled_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rdv_a_reg <= filled_reg[raddr_a];
                rdv_b_reg <= filled_reg[raddr_b];
            end
        end
    end

    assign rdata_a = rdv_a_reg ? rd_a_reg : '0;
    assign rdata_b = rdv_b_reg ? rd_b_reg : '0;

endmodule

`default_nettype wire

// ===== design/accident_doubt_point_capture.sv =====
// Top level of the point capture block: config registers, microcoded sequencer, datapath.
// Depends on adpc_pkg, adpc_if, adpc_ring and the assertion macro header.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+-------------------------------------------
//   in_ch    | in  | valid/ready      | speed, status_bits, supply_voltage
//   out_ch   | out | valid/ready      | pair of points, cause, last, valid, running
//   cfg      | in  | cfg_we, no ready | cfg_index, cfg_data
//
// A tick without a record runs the accept, debounce, store and trigger steps.
// A tick with a record runs the accept, debounce, store, trigger, read and done steps,
// plus one emit step and one loop step of the microcode for each of the READ_POINTS/2
// pairs, reading both points at once.
// A stalled out_ch holds the sequencer in its emit step; in_ch stays low until done.
// Reset clears the ring at once through per-entry valid bits; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "accident_doubt_point_capture_defines.svh"

module accident_doubt_point_capture #(
    parameter int RING_DEPTH  = adpc_pkg::RING_DEPTH_DEF,
    parameter int READ_POINTS = adpc_pkg::READ_POINTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [adpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [adpc_pkg::CFG_DATA_W-1:0] cfg_data,
    adpc_in_if.sink                             in_ch,
    adpc_out_if.source                          out_ch
);
    import adpc_pkg::*;

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int PAIRS = READ_POINTS / 2;
    localparam int PC_W  = $clog2(PAIRS + 1);
    localparam int RUN_W = $clog2(2 * PAIRS + 1);
    localparam int CMP_W = (RUN_W > VRP_W) ? RUN_W : VRP_W;

    localparam logic [AW:0]     DEPTH_X   = (AW + 1)'(RING_DEPTH);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(RING_DEPTH - 1);
    localparam logic [PC_W-1:0] PAIRS_C   = PC_W'(PAIRS);
    localparam logic [PC_W-1:0] LAST_PAIR = PC_W'(PAIRS - 1);

    // configuration
    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [VRP_W-1:0]      vrp_reg;
    logic [VOLT_W-1:0]     threshold_reg;

    // sequencer
    step_t  step_reg;
    step_t  step_next;
    ucode_t uw;
    logic   cond_hit;

    // tick state
    logic [SPEED_W-1:0]    spd_reg;
    logic [STATUS_W-1:0]   sts_reg;
    logic [VOLT_W-1:0]     volt_reg;
    logic [DEBOUNCE_W-1:0] moving_reg;
    logic [DEBOUNCE_W-1:0] moving_next;
    logic [DEBOUNCE_W-1:0] still_reg;
    logic [DEBOUNCE_W-1:0] still_next;
    logic                  running_reg;
    logic                  running_next;
    logic                  prev_running_reg;
    logic                  prev_lost_reg;
    logic [SAMPLE_W-1:0]   divider_reg;
    logic [SAMPLE_W-1:0]   divider_inc;
    logic [AW-1:0]         wp_reg;

    // record walk
    logic [AW-1:0]   pos_reg;
    logic [AW-1:0]   pos_dec1;
    logic [AW-1:0]   pos_dec2;
    logic [AW-1:0]   pos_start;
    logic [AW:0]     ofs_x;
    logic [AW:0]     off_x;
    logic [AW:0]     wp_x;
    logic [AW:0]     start_x;
    logic [PC_W-1:0] pair_cnt_reg;
    logic [RUN_W-1:0] run_reg;
    logic [RUN_W-1:0] run_a;
    logic [RUN_W-1:0] run_b;
    logic            rec_ok_reg;
    logic            ok_a;
    logic            ok_b;
    logic            nz_a;
    logic            nz_b;
    logic            cause_reg;
    logic            lost;
    logic            stop_trig;
    logic            power_trig;
    logic            trig;

    // ring
    logic               ring_we;
    logic               ring_re;
    logic [POINT_W-1:0] rdata_a;
    logic [POINT_W-1:0] rdata_b;

    // output register
    logic                out_valid_reg;
    logic [SPEED_W-1:0]  o_spd_new_reg;
    logic [STATUS_W-1:0] o_sts_new_reg;
    logic [SPEED_W-1:0]  o_spd_old_reg;
    logic [STATUS_W-1:0] o_sts_old_reg;
    logic                o_cause_reg;
    logic                o_last_reg;
    logic                o_rvalid_reg;
    logic                o_running_reg;
    logic                out_free;
    logic                push;
    logic                in_acc;

    assign uw       = ucode_rom(step_reg);
    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign push     = (uw.op == UOP_EMIT) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RST;
            sample_reg    <= SAMPLE_RST;
            offset_reg    <= OFFSET_RST;
            vrp_reg       <= VRP_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data[DEBOUNCE_W-1:0];
                CFG_SAMPLE:    sample_reg    <= cfg_data[SAMPLE_W-1:0];
                CFG_OFFSET:    offset_reg    <= cfg_data[OFFSET_W-1:0];
                CFG_VRP:       vrp_reg       <= cfg_data[VRP_W-1:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data[VOLT_W-1:0];
                default:       ;
            endcase
        end
    end

    // branch decode
    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:      cond_hit = 1'b0;
            C_ALWAYS:     cond_hit = 1'b1;
            C_NOT_ACCEPT: cond_hit = !in_acc;
            C_NO_TRIG:    cond_hit = !trig;
            C_OUT_BUSY:   cond_hit = !out_free;
            C_MORE_PAIRS: cond_hit = (pair_cnt_reg != PAIRS_C);
            default:      cond_hit = 1'b1;
        endcase
        step_next = cond_hit ? uw.target : step_reg + step_t'(1);
    end

    // debounce
    always_comb
    begin
        moving_next  = moving_reg;
        still_next   = still_reg;
        running_next = running_reg;
        if (spd_reg != '0)
        begin
            still_next = '0;
            if (moving_reg != '1)
            begin
                moving_next = moving_reg + DEBOUNCE_W'(1);
            end
            if (moving_next >= debounce_reg)
            begin
                if (moving_next != '0)
                begin
                    moving_next = moving_next - DEBOUNCE_W'(1);
                end
                running_next = 1'b1;
            end
        end
        else
        begin
            moving_next = '0;
            if (still_reg != '1)
            begin
                still_next = still_reg + DEBOUNCE_W'(1);
            end
            if (still_next >= debounce_reg)
            begin
                if (still_next != '0)
                begin
                    still_next = still_next - DEBOUNCE_W'(1);
                end
                running_next = 1'b0;
            end
        end
    end

    assign divider_inc = divider_reg + SAMPLE_W'(1);
    assign ring_we     = (uw.op == UOP_STORE) && (divider_inc >= sample_reg);

    // triggers
    assign lost       = (volt_reg <= threshold_reg);
    assign stop_trig  = prev_running_reg && !running_reg;
    assign power_trig = running_reg && !prev_lost_reg && lost;
    assign trig       = stop_trig || power_trig;

    // start position: newest point, minus offset on a stop
    always_comb
    begin
        ofs_x   = (AW + 1)'(offset_reg);
        off_x   = stop_trig ? ((ofs_x >= DEPTH_X) ? ofs_x - DEPTH_X : ofs_x) : '0;
        wp_x    = {1'b0, wp_reg};
        start_x = (wp_x > off_x) ? wp_x - off_x - (AW + 1)'(1)
                                 : wp_x + DEPTH_X - off_x - (AW + 1)'(1);
        pos_start = start_x[AW-1:0];
    end

    assign pos_dec1 = (pos_reg == '0) ? LAST_ADDR : pos_reg - AW'(1);
    assign pos_dec2 = (pos_dec1 == '0) ? LAST_ADDR : pos_dec1 - AW'(1);
    assign ring_re  = (uw.op == UOP_READ) || push;

    // run of nonzero speeds across the pair, newer point first
    always_comb
    begin
        nz_a  = (rdata_a[POINT_W-1:STATUS_W] != '0);
        run_a = nz_a ? run_reg + RUN_W'(1) : '0;
        ok_a  = rec_ok_reg || (nz_a && (CMP_W'(run_a) >= CMP_W'(vrp_reg)));
        nz_b  = (rdata_b[POINT_W-1:STATUS_W] != '0);
        run_b = nz_b ? run_a + RUN_W'(1) : '0;
        ok_b  = ok_a || (nz_b && (CMP_W'(run_b) >= CMP_W'(vrp_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= STEP_WAIT;
            moving_reg       <= '0;
            still_reg        <= '0;
            running_reg      <= 1'b0;
            prev_running_reg <= 1'b0;
            prev_lost_reg    <= 1'b0;
            divider_reg      <= '0;
            wp_reg           <= '0;
            pos_reg          <= '0;
            pair_cnt_reg     <= '0;
            run_reg          <= '0;
            rec_ok_reg       <= 1'b0;
            cause_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (uw.op == UOP_DEBOUNCE)
            begin
                moving_reg  <= moving_next;
                still_reg   <= still_next;
                running_reg <= running_next;
            end
            if (uw.op == UOP_STORE)
            begin
                divider_reg <= ring_we ? '0 : divider_inc;
                if (ring_we)
                begin
                    wp_reg <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + AW'(1);
                end
            end
            if (uw.op == UOP_TRIGGER)
            begin
                prev_running_reg <= running_reg;
                if (running_reg)
                begin
                    prev_lost_reg <= lost;
                end
                if (trig)
                begin
                    cause_reg    <= power_trig;
                    pos_reg      <= pos_start;
                    pair_cnt_reg <= '0;
                    run_reg      <= '0;
                    rec_ok_reg   <= 1'b0;
                end
            end
            if (ring_re)
            begin
                pos_reg <= pos_dec2;
            end
            if (push)
            begin
                pair_cnt_reg  <= pair_cnt_reg + PC_W'(1);
                run_reg       <= run_b;
                rec_ok_reg    <= ok_b;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            spd_reg  <= in_ch.speed;
            sts_reg  <= in_ch.status_bits;
            volt_reg <= in_ch.supply_voltage;
        end
        if (push)
        begin
            o_spd_new_reg <= rdata_a[POINT_W-1:STATUS_W];
            o_sts_new_reg <= rdata_a[STATUS_W-1:0];
            o_spd_old_reg <= rdata_b[POINT_W-1:STATUS_W];
            o_sts_old_reg <= rdata_b[STATUS_W-1:0];
            o_cause_reg   <= cause_reg;
            o_last_reg    <= (pair_cnt_reg == LAST_PAIR);
            o_rvalid_reg  <= (pair_cnt_reg == LAST_PAIR) && ok_b;
            o_running_reg <= running_reg;
        end
    end

    adpc_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (ring_we),
        .waddr   (wp_reg),
        .wdata   ({spd_reg, sts_reg}),
        .re      (ring_re),
        .raddr_a (pos_reg),
        .raddr_b (pos_dec1),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign in_ch.ready            = (uw.op == UOP_LATCH);
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.speed_newer     = o_spd_new_reg;
    assign out_ch.status_newer    = o_sts_new_reg;
    assign out_ch.speed_older     = o_spd_old_reg;
    assign out_ch.status_older    = o_sts_old_reg;
    assign out_ch.cause           = o_cause_reg;
    assign out_ch.record_last     = o_last_reg;
    assign out_ch.record_valid    = o_rvalid_reg;
    assign out_ch.vehicle_running = o_running_reg;

    `ADPC_ASSERT_IMP(a_pair_bound, 1'b1, pair_cnt_reg <= PAIRS_C, "pair count past record")
    `ADPC_ASSERT_IMP(a_rvalid_last, out_valid_reg && o_rvalid_reg, o_last_reg,
        "record valid off the last pair")
    `ADPC_ASSERT_IMP(a_ptr_range, 1'b1, (wp_reg <= LAST_ADDR) && (pos_reg <= LAST_ADDR),
        "ring pointer out of range")
    `ADPC_ASSERT_IMP(a_push_held, out_valid_reg && !out_ch.ready, !push,
        "pair pushed over a held item")
    `ADPC_ASSERT_NXT(a_held_kept, out_valid_reg && !out_ch.ready, out_valid_reg,
        "held item dropped")
    `ADPC_ASSERT_IMP(a_busy_no_accept, step_reg != STEP_WAIT, !in_ch.ready,
        "tick accepted mid-sequence")

endmodule

`default_nettype wire

// ===== tb/sv/accident_doubt_point_capture_tb.sv =====
// Self-checking testbench for accident_doubt_point_capture: drives tick items, predicts
// every record pair from its own recorder model and compares each pair field by field.
// Depends on adpc_pkg and the adpc_in_if / adpc_out_if interfaces of the design.
`timescale 1ns / 1ps

module accident_doubt_point_capture_tb;
    import adpc_pkg::*;

    localparam int RING_DEPTH    = RING_DEPTH_DEF;
    localparam int READ_POINTS   = READ_POINTS_DEF;
    localparam int PAIRS         = READ_POINTS / 2;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int IDLE_PERCENT  = 35;

    localparam bit CAUSE_STOP  = 1'b0;
    localparam bit CAUSE_POWER = 1'b1;

    typedef struct packed {
        logic [SPEED_W-1:0]  speed;
        logic [STATUS_W-1:0] status;
        logic [VOLT_W-1:0]   supply;
    } tick_t;

    typedef struct packed {
        logic [SPEED_W-1:0]  speed_newer;
        logic [STATUS_W-1:0] status_newer;
        logic [SPEED_W-1:0]  speed_older;
        logic [STATUS_W-1:0] status_older;
        logic                cause;
        logic                last;
        logic                rec_valid;
        logic                running;
    } pair_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  no_idle;

    adpc_in_if  tick_ch ();
    adpc_out_if pair_ch ();

    accident_doubt_point_capture u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (tick_ch),
        .out_ch    (pair_ch)
    );

    // recorder model state and register copies
    logic [DEBOUNCE_W-1:0] deb_ticks;
    logic [SAMPLE_W-1:0]   smp_ticks;
    logic [OFFSET_W-1:0]   stop_off;
    logic [VRP_W-1:0]      run_need;
    logic [VOLT_W-1:0]     lost_level;
    int unsigned           moving_cnt;
    int unsigned           still_cnt;
    bit                    running;
    bit                    was_running;
    bit                    was_lost;
    logic [SAMPLE_W-1:0]   smp_div;
    int unsigned           wr_ptr;
    logic [POINT_W-1:0]    ring [RING_DEPTH];

    tick_t       tick_backlog [$];
    pair_t       pending_pairs [$];
    int unsigned ticks_queued;
    int unsigned ticks_taken;
    int unsigned pairs_checked;
    int unsigned stop_records;
    int unsigned power_records;
    int unsigned settings_used;
    int unsigned errors;
    int unsigned quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void reset_recorder_model();
        deb_ticks   = DEBOUNCE_RST;
        smp_ticks   = SAMPLE_RST;
        stop_off    = OFFSET_RST;
        run_need    = VRP_RST;
        lost_level  = THRESHOLD_RST;
        moving_cnt  = 0;
        still_cnt   = 0;
        running     = 1'b0;
        was_running = 1'b0;
        was_lost    = 1'b0;
        smp_div     = '0;
        wr_ptr      = 0;
        for (int i = 0; i < RING_DEPTH; i++)
            ring[i] = '0;
    endfunction

    // walk the ring newest first and queue the pairs of one record
    function automatic void queue_record_pairs(input int unsigned offset, input bit cause_bit);
        int unsigned        pos;
        int unsigned        run_len;
        bit                 enough;
        logic [POINT_W-1:0] pt [2];
        pair_t              p;
        pos = (wr_ptr + 2 * RING_DEPTH - (offset % RING_DEPTH) - 1) % RING_DEPTH;
        run_len = 0;
        enough = 1'b0;
        for (int k = 0; k < PAIRS; k++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                pt[h] = ring[pos];
                if (pt[h][POINT_W-1:STATUS_W] != '0)
                begin
                    run_len++;
                    if (run_len >= run_need)
                        enough = 1'b1;
                end
                else
                    run_len = 0;
                pos = (pos == 0) ? RING_DEPTH - 1 : pos - 1;
            end
            p.speed_newer  = pt[0][POINT_W-1:STATUS_W];
            p.status_newer = pt[0][STATUS_W-1:0];
            p.speed_older  = pt[1][POINT_W-1:STATUS_W];
            p.status_older = pt[1][STATUS_W-1:0];
            p.cause        = cause_bit;
            p.last         = (k == PAIRS - 1);
            p.rec_valid    = (k == PAIRS - 1) && enough;
            p.running      = running;
            pending_pairs.push_back(p);
        end
        if (cause_bit == CAUSE_STOP)
            stop_records++;
        else
            power_records++;
    endfunction

    function automatic void advance_recorder(input logic [SPEED_W-1:0] speed,
                                             input logic [STATUS_W-1:0] status,
                                             input logic [VOLT_W-1:0] supply);
        bit lost;
        if (speed != '0)
        begin
            still_cnt = 0;
            if (moving_cnt < 32'hFFFF)
                moving_cnt++;
            if (moving_cnt >= deb_ticks)
            begin
                if (moving_cnt > 0)
                    moving_cnt--;
                running = 1'b1;
            end
        end
        else
        begin
            moving_cnt = 0;
            if (still_cnt < 32'hFFFF)
                still_cnt++;
            if (still_cnt >= deb_ticks)
            begin
                if (still_cnt > 0)
                    still_cnt--;
                running = 1'b0;
            end
        end
        smp_div = smp_div + 1'b1;
        if (smp_div >= smp_ticks)
        begin
            smp_div = '0;
            ring[wr_ptr] = {speed, status};
            wr_ptr = (wr_ptr + 1 >= RING_DEPTH) ? 0 : wr_ptr + 1;
        end
        if (was_running && !running)
            queue_record_pairs(stop_off, CAUSE_STOP);
        was_running = running;
        if (running)
        begin
            lost = (supply <= lost_level);
            if (!was_lost && lost)
                queue_record_pairs(0, CAUSE_POWER);
            was_lost = lost;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t pair %0d: %s", $time, pairs_checked, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // driver: present ticks from the backlog, advance the model on each accepted item
    always @(posedge clk)
    begin
        tick_t nxt;
        if (!rst_n)
            tick_ch.valid <= 1'b0;
        else
        begin
            if (tick_ch.valid && tick_ch.ready)
            begin
                advance_recorder(tick_ch.speed, tick_ch.status_bits, tick_ch.supply_voltage);
                ticks_taken++;
            end
            if (!tick_ch.valid || tick_ch.ready)
            begin
                if (tick_backlog.size() != 0
                    && (no_idle || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    nxt = tick_backlog.pop_front();
                    tick_ch.valid          <= 1'b1;
                    tick_ch.speed          <= nxt.speed;
                    tick_ch.status_bits    <= nxt.status;
                    tick_ch.supply_voltage <= nxt.supply;
                end
                else
                    tick_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: compare each accepted pair with the oldest pending one
    always @(posedge clk)
    begin
        pair_t want;
        if (!rst_n)
            pair_ch.ready <= 1'b0;
        else
        begin
            if (pair_ch.valid && pair_ch.ready)
            begin
                if (pending_pairs.size() == 0)
                    report_mismatch("pair item with no record pending");
                else
                begin
                    want = pending_pairs.pop_front();
                    check_field("speed_newer", pair_ch.speed_newer, want.speed_newer);
                    check_field("status_newer", pair_ch.status_newer, want.status_newer);
                    check_field("speed_older", pair_ch.speed_older, want.speed_older);
                    check_field("status_older", pair_ch.status_older, want.status_older);
                    check_field("cause", 8'(pair_ch.cause), 8'(want.cause));
                    check_field("record_last", 8'(pair_ch.record_last), 8'(want.last));
                    check_field("record_valid", 8'(pair_ch.record_valid),
                                8'(want.rec_valid));
                    check_field("vehicle_running", 8'(pair_ch.vehicle_running),
                                8'(want.running));
                end
                pairs_checked++;
            end
            pair_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (pair_ch.valid && pair_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    function automatic void queue_tick(input logic [SPEED_W-1:0] speed,
                                       input logic [STATUS_W-1:0] status,
                                       input logic [VOLT_W-1:0] supply);
        tick_t t;
        t.speed  = speed;
        t.status = status;
        t.supply = supply;
        tick_backlog.push_back(t);
        ticks_queued++;
    endfunction

    function automatic logic [VOLT_W-1:0] supply_level(input bit low);
        if (low)
            return VOLT_W'($urandom_range(lost_level, 0));
        else if (lost_level == '1)
            return VOLT_W'($urandom_range(1023, 0));
        else
            return VOLT_W'($urandom_range(1023, lost_level + 1));
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_DEBOUNCE:  deb_ticks  = val;
            CFG_SAMPLE:    smp_ticks  = val[SAMPLE_W-1:0];
            CFG_OFFSET:    stop_off   = val[OFFSET_W-1:0];
            CFG_VRP:       run_need   = val[VRP_W-1:0];
            CFG_THRESHOLD: lost_level = val[VOLT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_setting(input int unsigned deb, input int unsigned smp,
                                 input int unsigned off, input int unsigned need,
                                 input int unsigned level);
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
        write_reg(CFG_SAMPLE, CFG_DATA_W'(smp));
        write_reg(CFG_OFFSET, CFG_DATA_W'(off));
        write_reg(CFG_VRP, CFG_DATA_W'(need));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(level));
        settings_used++;
    endtask

    // hold until the backlog is sent and every pending pair has come back
    task automatic wait_idle();
        while (tick_backlog.size() != 0 || tick_ch.valid || pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one drive: enough moving ticks to start running, occasional supply dips, then a stop
    task automatic queue_trip();
        int unsigned go_len;
        int unsigned stop_len;
        go_len = deb_ticks + $urandom_range(10);
        if ($urandom_range(5) == 0)
            go_len += $urandom_range(60);
        stop_len = deb_ticks + $urandom_range(3);
        for (int i = 0; i < go_len; i++)
            queue_tick(SPEED_W'($urandom_range(255, 1)), STATUS_W'($urandom_range(255)),
                       supply_level($urandom_range(7) == 0));
        for (int i = 0; i < stop_len; i++)
            queue_tick(8'd0, STATUS_W'($urandom_range(255)),
                       supply_level($urandom_range(3) == 0));
    endtask

    task automatic queue_random_ticks(input int unsigned target);
        int unsigned start;
        start = ticks_queued;
        while (ticks_queued - start < target)
        begin
            if ($urandom_range(4) != 0)
                queue_trip();
            else
                repeat ($urandom_range(4, 1))
                    queue_tick(SPEED_W'($urandom_range(255)), STATUS_W'($urandom_range(255)),
                               VOLT_W'($urandom_range(1023)));
        end
    endtask

    initial
    begin
        reset_recorder_model();
        ticks_queued  = 0;
        ticks_taken   = 0;
        pairs_checked = 0;
        stop_records  = 0;
        power_records = 0;
        settings_used = 0;
        errors        = 0;
        quiet_cycles  = 0;
        no_idle       = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tick_ch.valid          = 1'b0;
        tick_ch.speed          = '0;
        tick_ch.status_bits    = '0;
        tick_ch.supply_voltage = '0;
        pair_ch.ready          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: long debounce, power check skipped while stopped
        queue_tick(8'd255, 8'd255, 10'd1023);
        queue_tick(8'd0, 8'd0, 10'd0);
        queue_tick(8'd255, 8'd0, 10'd0);
        queue_tick(8'd0, 8'd255, 10'd1023);
        wait_idle();

        // immediate debounce, store every tick, no stop offset, any supply counts as lost
        write_setting(1, 1, 0, 1, 1023);
        queue_tick(8'd255, 8'hA5, 10'd1023);
        queue_tick(8'd0, 8'h5A, 10'd1023);
        queue_tick(8'd1, 8'hFF, 10'd512);
        queue_tick(8'd0, 8'd0, 10'd0);
        wait_idle();

        // sparse storing, deepest stop offset, full run needed, only zero supply is lost
        write_setting(2, 255, 149, 100, 0);
        queue_tick(8'd200, 8'h0F, 10'd100);
        queue_tick(8'd200, 8'hF0, 10'd100);
        queue_tick(8'd7, 8'h3C, 10'd0);
        queue_tick(8'd0, 8'hC3, 10'd1023);
        queue_tick(8'd0, 8'h81, 10'd1023);
        wait_idle();

        // longest debounce: running state never changes here
        write_setting(65535, 3, 75, 10, 512);
        queue_tick(8'd255, 8'h80, 10'd1023);
        queue_tick(8'd0, 8'h01, 10'd0);
        queue_tick(8'd128, 8'h7F, 10'd512);
        queue_tick(8'd0, 8'hFE, 10'd1);
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_setting($urandom_range(4, 1),
                          (ph == 3) ? $urandom_range(255, 1) : $urandom_range(5, 1),
                          $urandom_range(149, 0),
                          (ph == 1) ? $urandom_range(100, 1) : $urandom_range(20, 1),
                          $urandom_range(900, 60));
            no_idle <= (ph == 2);
            queue_random_ticks(32);
            wait_idle();
        end

        $display("Ran %0d ticks under %0d register settings", ticks_taken, settings_used);
        $display("Checked %0d pairs from %0d stop and %0d power-loss records",
                 pairs_checked, stop_records, power_records);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
